/* sv/log_sum_exp_argmax_defines.svh */
// assertion macros for the log-sum-exp block
`ifndef LOG_SUM_EXP_ARGMAX_DEFINES_SVH
`define LOG_SUM_EXP_ARGMAX_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lse_pkg.sv */
// shared constants, types and table builders for the log-sum-exp block
`default_nettype none
package lse_pkg;

    localparam int DEF_MAX_ITEMS = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int VAL_W  = 32;
    localparam int Q_W    = 31;
    localparam int PROD_W = 2 * Q_W;
    localparam int CTAB_N = 32;

    localparam logic [Q_W-1:0] ONE_Q30   = 31'd1073741824;
    localparam logic [Q_W-1:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [Q_W-1:0] LN2_Q30   = 31'd744261118;

    typedef logic [Q_W-1:0] t_ctab [0:CTAB_N-1];

    // truncating integer square root, digit by digit
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x   = x_in;
        res = '0;
        for (int k = 31; k >= 0; k--) begin
            bitv = 64'd1 << (2 * k);
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // c[0]=1, c[j]=2^(-2^-j) in q30 to j=24, each the sqrt of the last
    function automatic t_ctab build_ctab();
        t_ctab       tab;
        logic [63:0] prev;
        for (int j = 0; j < CTAB_N; j++) begin
            tab[j] = '0;
        end
        tab[0] = ONE_Q30;
        prev   = isqrt64(64'd1 << 59);
        tab[1] = prev[Q_W-1:0];
        for (int j = 2; j <= 24; j++) begin
            prev   = isqrt64(prev << 30);
            tab[j] = prev[Q_W-1:0];
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

/* sv/lse_if.sv */
// valid/ready channels for input and result words
`default_nettype none
interface lse_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] log_value;
    logic               last;
    modport source (output valid, output log_value, output last, input ready);
    modport sink   (input valid, input log_value, input last, output ready);
endinterface

interface lse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] log_sum;
    logic [5:0]         max_index;
    logic [6:0]         item_count;
    logic               overflow;
    modport source (output valid, output log_sum, output max_index, output item_count,
                    output overflow, input ready);
    modport sink   (input valid, input log_sum, input max_index, input item_count,
                    input overflow, output ready);
endinterface
`default_nettype wire

/* sv/lse_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module lse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/log_sum_exp_argmax.sv */
// log-sum-exp over a list of q16.16 log-values, with position of the maximum
//
// input channel i_in: one log_value per word, last marks the end of a list.
// words load at one per cycle; the running maximum and its first position
// are tracked as they arrive. words beyond MAX_ITEMS are dropped and flagged.
// after the last word the block drops ready and walks the stored list with
// one shared 31x31 multiplier: the exponential of each stored value is built
// bit by bit from its fraction, and is skipped (term zero) when the value is
// more than 16 below the max. ln of the sum then comes from normalizing it
// into [1, 2), squaring it repeatedly for 30 fraction bits of log2, and
// scaling by ln 2 before adding the max.
// output channel o_out: one result word per list, held in a register until
// taken; a new list may load while that word waits, but the final step of
// the next list holds until the output register is free.
// reset (synchronous, active low) empties the list and drops o_out.valid;
// the value store itself is not cleared.
`default_nettype none
`include "log_sum_exp_argmax_defines.svh"
module log_sum_exp_argmax #(
    parameter int MAX_ITEMS = lse_pkg::DEF_MAX_ITEMS,
    parameter int FRAC_BITS = lse_pkg::DEF_FRAC_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lse_in_if.sink    i_in,
    lse_out_if.source o_out
);
    import lse_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W  = ADDR_W + 31;
    localparam int P_W    = ADDR_W + 1;
    localparam int LNQ_W  = P_W + 31;
    localparam int RES_W  = LNQ_W + 33;
    localparam int T_W    = FRAC_BITS + 5;
    localparam int N_W    = T_W - FRAC_BITS;
    localparam int STEP_W = 5;

    localparam t_ctab C_TAB = build_ctab();
    localparam logic [32:0] NEG_LIM = 33'(16) << FRAC_BITS;
    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32'sh7fffffff);
    localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

    typedef enum logic [3:0] {
        S_LOAD, S_RD, S_NEG, S_EXP, S_ADD, S_NORM, S_SQ, S_LN1, S_LN2, S_OUT
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic signed [31:0]       r_max;
    logic [ADDR_W-1:0]        r_pos;
    logic                     r_ovf;
    logic [ADDR_W-1:0]        r_idx;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_zero;
    logic [Q_W-1:0]           r_acc;
    logic [FRAC_BITS-1:0]     r_rbits;
    logic [N_W-1:0]           r_n;
    logic [STEP_W-1:0]        r_step;
    logic [SUM_W-1:0]         r_m;
    logic [P_W-1:0]           r_p;
    logic [29:0]              r_lfrac;
    logic [LNQ_W-1:0]         r_lnq;

    logic                     r_out_valid;
    logic signed [31:0]       r_out_sum;
    logic [5:0]               r_out_idx;
    logic [6:0]               r_out_cnt;
    logic                     r_out_ovf;

    logic                     in_fire;
    logic                     store_ok;
    logic [31:0]              rd_data;
    logic [32:0]              diff;
    logic [Q_W-1:0]           mul_a;
    logic [Q_W-1:0]           mul_b;
    logic [PROD_W-1:0]        prod;
    logic [SUM_W-1:0]         term;
    logic [SUM_W-1:0]         n_sum;
    logic                     idx_last;
    logic [31:0]              sq;
    logic [LNQ_W-1:0]         lnq_sh;
    logic signed [RES_W-1:0]  res;
    logic signed [31:0]       res_sat;
    logic                     out_free;
    logic [ADDR_W+5:0]        pos_ext;
    logic [CNT_W+6:0]         cnt_ext;

    assign in_fire  = i_in.valid && i_in.ready;
    assign store_ok = r_count < CNT_W'(MAX_ITEMS);
    assign out_free = !r_out_valid || o_out.ready;

    lse_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_fire && store_ok),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.log_value),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // distance below the max, never negative
    assign diff = {r_max[31], r_max} - {rd_data[31], rd_data};

    // the one shared multiplier
    always_comb begin
        unique case (r_state)
            S_NEG: begin
                mul_a = Q_W'(diff[T_W-1:0]);
                mul_b = LOG2E_Q30;
            end
            S_EXP: begin
                mul_a = r_acc;
                mul_b = C_TAB[r_step];
            end
            S_SQ: begin
                mul_a = r_m[Q_W-1:0];
                mul_b = r_m[Q_W-1:0];
            end
            S_LN1: begin
                mul_a = {1'b0, r_lfrac};
                mul_b = LN2_Q30;
            end
            S_LN2: begin
                mul_a = Q_W'(r_p);
                mul_b = LN2_Q30;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign term     = r_zero ? '0 : SUM_W'(r_acc >> r_n);
    assign n_sum    = r_sum + term;
    assign idx_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign sq       = prod[61:30];

    assign lnq_sh  = r_lnq >> (30 - FRAC_BITS);
    assign res     = {{(RES_W-32){r_max[31]}}, r_max} + {{(RES_W-LNQ_W){1'b0}}, lnq_sh};
    assign pos_ext = (ADDR_W+6)'(r_pos);
    assign cnt_ext = (CNT_W+7)'(r_count);

    always_comb begin
        priority if (res > SAT_HI) begin
            res_sat = 32'sh7fffffff;
        end else if (res < SAT_LO) begin
            res_sat = 32'sh80000000;
        end else begin
            res_sat = res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_max       <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !(r_state == S_OUT && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (store_ok) begin
                            if (r_count == '0 || i_in.log_value > r_max) begin
                                r_max <= i_in.log_value;
                                r_pos <= r_count[ADDR_W-1:0];
                            end
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.last) begin
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    r_acc   <= ONE_Q30;
                    r_step  <= STEP_W'(1);
                    r_rbits <= prod[30+FRAC_BITS-1:30];
                    r_n     <= prod[30+T_W-1:30+FRAC_BITS];
                    if (diff > NEG_LIM) begin
                        // too far below the max, term is zero
                        r_zero  <= 1'b1;
                        r_state <= S_ADD;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_rbits[FRAC_BITS-1]) begin
                        r_acc <= prod[60:30];
                    end
                    r_rbits <= r_rbits << 1;
                    if (r_step == STEP_W'(FRAC_BITS)) begin
                        r_state <= S_ADD;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_ADD: begin
                    r_sum <= n_sum;
                    if (idx_last) begin
                        r_m     <= (n_sum < SUM_W'(ONE_Q30)) ? SUM_W'(ONE_Q30) : n_sum;
                        r_p     <= '0;
                        r_state <= S_NORM;
                    end else begin
                        r_idx   <= r_idx + ADDR_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_NORM: begin
                    // bring the sum into [1, 2) in q30
                    if (|r_m[SUM_W-1:31]) begin
                        r_m <= r_m >> 1;
                        r_p <= r_p + P_W'(1);
                    end else begin
                        r_step  <= '0;
                        r_lfrac <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (sq[31]) begin
                        r_m <= SUM_W'(sq[31:1]);
                    end else begin
                        r_m <= SUM_W'(sq);
                    end
                    r_lfrac <= {r_lfrac[28:0], sq[31]};
                    if (r_step == STEP_W'(29)) begin
                        r_state <= S_LN1;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_LN1: begin
                    r_lnq   <= LNQ_W'(prod[61:30]);
                    r_state <= S_LN2;
                end
                S_LN2: begin
                    r_lnq   <= r_lnq + LNQ_W'(prod);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sum   <= res_sat;
                        r_out_idx   <= pos_ext[5:0];
                        r_out_cnt   <= cnt_ext[6:0];
                        r_out_ovf   <= r_ovf;
                        r_count     <= '0;
                        r_max       <= '0;
                        r_pos       <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_LOAD);
    assign o_out.valid      = r_out_valid;
    assign o_out.log_sum    = r_out_sum;
    assign o_out.max_index  = r_out_idx;
    assign o_out.item_count = r_out_cnt;
    assign o_out.overflow   = r_out_ovf;

    `LSE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ITEMS), "count past capacity")
    `LSE_ASSERT_IMP(a_sq_range, i_clk, i_rst_n, r_state == S_SQ, r_m[SUM_W-1:31] == '0, "mantissa not normalized")
    `LSE_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, in_fire && i_in.last, r_state == S_RD, "last word did not start the sum")
    `LSE_ASSERT_NXT(a_out_clears, i_clk, i_rst_n, r_state == S_OUT && out_free, r_out_valid && r_count == '0 && r_state == S_LOAD, "result not issued or list not cleared")

endmodule
`default_nettype wire
